[src/cau_pkg.sv]
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Operation codes carried on the request side-band.
	typedef enum logic [2:0] {
		FN_ADD    = 3'd0,
		FN_MUL    = 3'd1,
		FN_DIV    = 3'd2,
		FN_MAG_A  = 3'd3,
		FN_MAG_B  = 3'd4,
		FN_CONJ_A = 3'd5,
		FN_CONJ_B = 3'd6
	} func_t;

	// Control that travels with a request through the iterative stages.
	typedef struct packed {
		logic  valid;
		func_t func;
		logic  neg_re;
		logic  neg_im;
		logic  big_re;
		logic  big_im;
		logic  dz;
		logic  early_ovf;
	} ctrl_t;

endpackage

[src/cau_step.sv]
module cau_step import cau_pkg::*; #(
	parameter int W   = DATA_WIDTH_DEF,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctrl_t             ctrl_i,
	input  logic [W-1:0]      early_re_i,
	input  logic [W-1:0]      early_im_i,
	input  logic [2*W-1:0]    d_i,
	input  logic [2*W-1:0]    rre_i,
	input  logic [W:0]        qre_i,
	input  logic [W:0]        nre_i,
	input  logic [2*W-1:0]    rim_i,
	input  logic [W:0]        qim_i,
	input  logic [W:0]        nim_i,
	input  logic [W+1:0]      srem_i,
	input  logic [W-1:0]      sroot_i,
	input  logic [2*W-1:0]    sbits_i,
	output ctrl_t             ctrl_o,
	output logic [W-1:0]      early_re_o,
	output logic [W-1:0]      early_im_o,
	output logic [2*W-1:0]    d_o,
	output logic [2*W-1:0]    rre_o,
	output logic [W:0]        qre_o,
	output logic [W:0]        nre_o,
	output logic [2*W-1:0]    rim_o,
	output logic [W:0]        qim_o,
	output logic [W:0]        nim_o,
	output logic [W+1:0]      srem_o,
	output logic [W-1:0]      sroot_o,
	output logic [2*W-1:0]    sbits_o
);

	localparam int DW = 2 * W;

	logic [DW:0]   tre, tim;
	logic [DW-1:0] rre_n, rim_n;
	logic          bre, bim;
	logic [W+1:0]  rn, trial, srem_n;
	logic [W-1:0]  sroot_n;
	logic [DW-1:0] sbits_n;

	ctrl_t         ctrl_q;
	logic [W-1:0]  early_re_q, early_im_q;
	logic [DW-1:0] d_q, rre_q, rim_q, sbits_q;
	logic [W:0]    qre_q, nre_q, qim_q, nim_q;
	logic [W+1:0]  srem_q;
	logic [W-1:0]  sroot_q;

	// One restoring division step on each quotient part.
	always_comb begin
		tre = {rre_i, nre_i[W]};
		tim = {rim_i, nim_i[W]};
		bre = (tre >= {1'b0, d_i});
		bim = (tim >= {1'b0, d_i});
		rre_n = bre ? DW'(tre - {1'b0, d_i}) : tre[DW-1:0];
		rim_n = bim ? DW'(tim - {1'b0, d_i}) : tim[DW-1:0];
	end

	// One digit of the square root, or a plain pass once all digits are done.
	always_comb begin
		rn    = {srem_i[W-1:0], sbits_i[DW-1:DW-2]};
		trial = {sroot_i, 2'b01};
		if (IDX < W) begin
			if (rn >= trial) begin
				srem_n  = rn - trial;
				sroot_n = {sroot_i[W-2:0], 1'b1};
			end else begin
				srem_n  = rn;
				sroot_n = {sroot_i[W-2:0], 1'b0};
			end
			sbits_n = {sbits_i[DW-3:0], 2'b00};
		end else begin
			srem_n  = srem_i;
			sroot_n = sroot_i;
			sbits_n = sbits_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			early_re_q <= early_re_i;
			early_im_q <= early_im_i;
			d_q        <= d_i;
			rre_q      <= rre_n;
			rim_q      <= rim_n;
			qre_q      <= {qre_i[W-1:0], bre};
			qim_q      <= {qim_i[W-1:0], bim};
			nre_q      <= {nre_i[W-1:0], 1'b0};
			nim_q      <= {nim_i[W-1:0], 1'b0};
			srem_q     <= srem_n;
			sroot_q    <= sroot_n;
			sbits_q    <= sbits_n;
		end
	end

	assign ctrl_o     = ctrl_q;
	assign early_re_o = early_re_q;
	assign early_im_o = early_im_q;
	assign d_o        = d_q;
	assign rre_o      = rre_q;
	assign rim_o      = rim_q;
	assign qre_o      = qre_q;
	assign qim_o      = qim_q;
	assign nre_o      = nre_q;
	assign nim_o      = nim_q;
	assign srem_o     = srem_q;
	assign sroot_o    = sroot_q;
	assign sbits_o    = sbits_q;

endmodule

[src/complex_arith_unit_top.sv]
// Complex arithmetic unit on signed fixed-point operands.
// Throughput: one request per cycle while the skid register is empty; the divider and square
// root each resolve one quotient or root bit per pipeline stage, so DATA_WIDTH + 1 iterative
// stages set the depth. Reset (arst_n low) clears the valid bits of the pipeline, output
// and skid registers, and the whole control word from stage 5 to the final stage.
module complex_arith_unit_top import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0 up: a_re, a_im, b_re, b_im, zero fill to whole bytes.
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
	// Fields from bit 0 up: func.
	input  logic [2:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0 up: res_re, res_im, zero fill to whole bytes.
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
	// Fields from bit 0 up: div_by_zero, overflow.
	output logic [1:0]                            m_tuser
);

	localparam int W      = DATA_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int DW     = 2 * W;
	localparam int NW     = DW + F + 1;
	localparam int CW     = DW + W + F;
	localparam int OUT_DW = ((2*DATA_WIDTH+7)/8)*8;
	localparam logic [DW:0] HALF = ((DW+1)'(1) << F) >> 1;

	// Saturate a sign-magnitude value to W bits; the top bit of the result is
	// the overflow flag.
	function automatic logic [W:0] sat_f(input logic neg, input logic [DW:0] m,
			input logic big);
		logic [DW:0] lim;
		logic [DW:0] v;
		logic        ovf;
		lim = neg ? ((DW+1)'(1) << (W-1)) : (((DW+1)'(1) << (W-1)) - (DW+1)'(1));
		ovf = big || (m > lim);
		v   = ovf ? lim : m;
		if (neg) begin
			v = -v;
		end
		return {ovf, v[W-1:0]};
	endfunction

	// The whole pipeline moves as one while the skid register is empty. When the
	// consumer stalls, the one result arriving lands in the skid register and
	// the pipeline halts on the next cycle, so nothing is lost or repeated.
	logic adv;
	logic skid_valid_q;
	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	// Stage 1: capture the request.
	logic                valid_s1;
	func_t               func_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func_t'(s_tuser);
			ar_s1   <= s_tdata[W-1:0];
			ai_s1   <= s_tdata[2*W-1:W];
			br_s1   <= s_tdata[3*W-1:2*W];
			bi_s1   <= s_tdata[4*W-1:3*W];
		end
	end

	// Stage 2: all partial products, plus the exact sum or conjugate.
	logic                 valid_s2;
	func_t                func_s2;
	logic signed [DW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [DW-1:0] q_ar_s2, q_ai_s2, q_br_s2, q_bi_s2;
	logic signed [W:0]    lin_re_s2, lin_im_s2;
	logic signed [W:0]    lin_re, lin_im;

	always_comb begin
		case (func_s1)
			FN_ADD: begin
				lin_re = {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
				lin_im = {ai_s1[W-1], ai_s1} + {bi_s1[W-1], bi_s1};
			end
			FN_CONJ_A: begin
				lin_re = {ar_s1[W-1], ar_s1};
				lin_im = -{ai_s1[W-1], ai_s1};
			end
			FN_CONJ_B: begin
				lin_re = {br_s1[W-1], br_s1};
				lin_im = -{bi_s1[W-1], bi_s1};
			end
			default: begin
				lin_re = '0;
				lin_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2   <= func_s1;
			p_rr_s2   <= ar_s1 * br_s1;
			p_ii_s2   <= ai_s1 * bi_s1;
			p_ri_s2   <= ar_s1 * bi_s1;
			p_ir_s2   <= ai_s1 * br_s1;
			q_ar_s2   <= ar_s1 * ar_s1;
			q_ai_s2   <= ai_s1 * ai_s1;
			q_br_s2   <= br_s1 * br_s1;
			q_bi_s2   <= bi_s1 * bi_s1;
			lin_re_s2 <= lin_re;
			lin_im_s2 <= lin_im;
		end
	end

	// Stage 3: combine products. Multiply and divide share the numerator path;
	// the two magnitude codes share the sum of squares. Sum and conjugate are
	// saturated here and ride along as the early result.
	logic                 valid_s3;
	func_t                func_s3;
	logic signed [DW:0]   x_re_s3, x_im_s3;
	logic [DW-1:0]        den_s3, sqs_s3;
	logic [W-1:0]         early_re_s3, early_im_s3;
	logic                 eovf_s3;
	logic signed [DW:0]   x_re, x_im;
	logic [DW-1:0]        sqs;
	logic [W:0]           lsat_re, lsat_im;

	always_comb begin
		if (func_s2 == FN_MUL) begin
			x_re = {p_rr_s2[DW-1], p_rr_s2} - {p_ii_s2[DW-1], p_ii_s2};
			x_im = {p_ri_s2[DW-1], p_ri_s2} + {p_ir_s2[DW-1], p_ir_s2};
		end else begin
			x_re = {p_rr_s2[DW-1], p_rr_s2} + {p_ii_s2[DW-1], p_ii_s2};
			x_im = {p_ir_s2[DW-1], p_ir_s2} - {p_ri_s2[DW-1], p_ri_s2};
		end
		if (func_s2 == FN_MAG_A) begin
			sqs = DW'(q_ar_s2) + DW'(q_ai_s2);
		end else begin
			sqs = DW'(q_br_s2) + DW'(q_bi_s2);
		end
		lsat_re = sat_f(lin_re_s2[W], (DW+1)'(lin_re_s2[W] ? -lin_re_s2 : lin_re_s2), 1'b0);
		lsat_im = sat_f(lin_im_s2[W], (DW+1)'(lin_im_s2[W] ? -lin_im_s2 : lin_im_s2), 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s3     <= func_s2;
			x_re_s3     <= x_re;
			x_im_s3     <= x_im;
			den_s3      <= DW'(q_br_s2) + DW'(q_bi_s2);
			sqs_s3      <= sqs;
			early_re_s3 <= lsat_re[W-1:0];
			early_im_s3 <= lsat_im[W-1:0];
			eovf_s3     <= lsat_re[W] | lsat_im[W];
		end
	end

	// Stage 4: split the numerator parts into sign and magnitude.
	logic          valid_s4;
	func_t         func_s4;
	logic          neg_re_s4, neg_im_s4, dz_s4;
	logic [DW-1:0] mag_re_s4, mag_im_s4, den_s4, sqs_s4;
	logic [W-1:0]  early_re_s4, early_im_s4;
	logic          eovf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s4     <= func_s3;
			neg_re_s4   <= x_re_s3[DW];
			neg_im_s4   <= x_im_s3[DW];
			mag_re_s4   <= DW'(x_re_s3[DW] ? -x_re_s3 : x_re_s3);
			mag_im_s4   <= DW'(x_im_s3[DW] ? -x_im_s3 : x_im_s3);
			den_s4      <= den_s3;
			sqs_s4      <= sqs_s3;
			dz_s4       <= (func_s3 == FN_DIV) && (den_s3 == '0);
			early_re_s4 <= early_re_s3;
			early_im_s4 <= early_im_s3;
			eovf_s4     <= eovf_s3;
		end
	end

	// Stage 5: round and saturate the product, and set up both dividers and
	// the square root. A quotient whose doubled value does not fit in W+1 bits
	// is flagged as too big and saturates at the end.
	ctrl_t         ctrl_s5;
	logic [W-1:0]  early_re_s5, early_im_s5;
	logic [DW-1:0] d_s5, rre_s5, rim_s5, sbits_s5;
	logic [W:0]    nre_s5, nim_s5;

	logic [DW:0]   mr_re, mr_im;
	logic [W:0]    msat_re, msat_im;
	logic [NW-1:0] nfull_re, nfull_im;
	logic [W+F-1:0] hi_re, hi_im;
	ctrl_t         ctrl_n5;
	logic [W-1:0]  early_re_n5, early_im_n5;

	always_comb begin
		mr_re    = ({1'b0, mag_re_s4} + HALF) >> F;
		mr_im    = ({1'b0, mag_im_s4} + HALF) >> F;
		msat_re  = sat_f(neg_re_s4, mr_re, 1'b0);
		msat_im  = sat_f(neg_im_s4, mr_im, 1'b0);
		nfull_re = {mag_re_s4, {(F+1){1'b0}}};
		nfull_im = {mag_im_s4, {(F+1){1'b0}}};
		hi_re    = nfull_re[NW-1:W+1];
		hi_im    = nfull_im[NW-1:W+1];

		ctrl_n5.valid  = valid_s4;
		ctrl_n5.func   = func_s4;
		ctrl_n5.neg_re = neg_re_s4;
		ctrl_n5.neg_im = neg_im_s4;
		ctrl_n5.big_re = CW'(hi_re) >= CW'(den_s4);
		ctrl_n5.big_im = CW'(hi_im) >= CW'(den_s4);
		ctrl_n5.dz     = dz_s4;
		if (func_s4 == FN_MUL) begin
			early_re_n5       = msat_re[W-1:0];
			early_im_n5       = msat_im[W-1:0];
			ctrl_n5.early_ovf = msat_re[W] | msat_im[W];
		end else begin
			early_re_n5       = early_re_s4;
			early_im_n5       = early_im_s4;
			ctrl_n5.early_ovf = eovf_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s5 <= '0;
		end else if (adv) begin
			ctrl_s5 <= ctrl_n5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			early_re_s5 <= early_re_n5;
			early_im_s5 <= early_im_n5;
			d_s5        <= den_s4;
			rre_s5      <= DW'(hi_re);
			rim_s5      <= DW'(hi_im);
			nre_s5      <= nfull_re[W:0];
			nim_s5      <= nfull_im[W:0];
			sbits_s5    <= sqs_s4;
		end
	end

	// Iterative stages: W+1 quotient bits for each divider, W root digits.
	ctrl_t         ctrl_c  [0:W+1];
	logic [W-1:0]  ere_c   [0:W+1];
	logic [W-1:0]  eim_c   [0:W+1];
	logic [DW-1:0] d_c     [0:W+1];
	logic [DW-1:0] rre_c   [0:W+1];
	logic [W:0]    qre_c   [0:W+1];
	logic [W:0]    nre_c   [0:W+1];
	logic [DW-1:0] rim_c   [0:W+1];
	logic [W:0]    qim_c   [0:W+1];
	logic [W:0]    nim_c   [0:W+1];
	logic [W+1:0]  srem_c  [0:W+1];
	logic [W-1:0]  sroot_c [0:W+1];
	logic [DW-1:0] sbits_c [0:W+1];

	assign ctrl_c[0]  = ctrl_s5;
	assign ere_c[0]   = early_re_s5;
	assign eim_c[0]   = early_im_s5;
	assign d_c[0]     = d_s5;
	assign rre_c[0]   = rre_s5;
	assign qre_c[0]   = '0;
	assign nre_c[0]   = nre_s5;
	assign rim_c[0]   = rim_s5;
	assign qim_c[0]   = '0;
	assign nim_c[0]   = nim_s5;
	assign srem_c[0]  = '0;
	assign sroot_c[0] = '0;
	assign sbits_c[0] = sbits_s5;

	for (genvar i = 0; i <= W; i++) begin : g_step
		cau_step #(
			.W   (W),
			.IDX (i)
		) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.ctrl_i     (ctrl_c[i]),
			.early_re_i (ere_c[i]),
			.early_im_i (eim_c[i]),
			.d_i        (d_c[i]),
			.rre_i      (rre_c[i]),
			.qre_i      (qre_c[i]),
			.nre_i      (nre_c[i]),
			.rim_i      (rim_c[i]),
			.qim_i      (qim_c[i]),
			.nim_i      (nim_c[i]),
			.srem_i     (srem_c[i]),
			.sroot_i    (sroot_c[i]),
			.sbits_i    (sbits_c[i]),
			.ctrl_o     (ctrl_c[i+1]),
			.early_re_o (ere_c[i+1]),
			.early_im_o (eim_c[i+1]),
			.d_o        (d_c[i+1]),
			.rre_o      (rre_c[i+1]),
			.qre_o      (qre_c[i+1]),
			.nre_o      (nre_c[i+1]),
			.rim_o      (rim_c[i+1]),
			.qim_o      (qim_c[i+1]),
			.nim_o      (nim_c[i+1]),
			.srem_o     (srem_c[i+1]),
			.sroot_o    (sroot_c[i+1]),
			.sbits_o    (sbits_c[i+1])
		);
	end

	// Final stage: round the quotients (half of the doubled quotient plus its
	// last bit) and the root (up by one when the remainder exceeds the root).
	ctrl_t        ctrl_f1;
	logic [W-1:0] early_re_f1, early_im_f1;
	logic [W:0]   qm_re_f1, qm_im_f1, root_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_f1 <= '0;
		end else if (adv) begin
			ctrl_f1 <= ctrl_c[W+1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			early_re_f1 <= ere_c[W+1];
			early_im_f1 <= eim_c[W+1];
			qm_re_f1    <= {1'b0, qre_c[W+1][W:1]} + (W+1)'(qre_c[W+1][0]);
			qm_im_f1    <= {1'b0, qim_c[W+1][W:1]} + (W+1)'(qim_c[W+1][0]);
			root_f1     <= (W+1)'(sroot_c[W+1]) +
				(W+1)'(srem_c[W+1] > (W+2)'(sroot_c[W+1]));
		end
	end

	// Pick the result for the operation and saturate it.
	logic [W-1:0] res_re, res_im;
	logic         res_dz, res_ovf;
	logic [W:0]   fre, fim;

	always_comb begin
		fre     = '0;
		fim     = '0;
		res_re  = early_re_f1;
		res_im  = early_im_f1;
		res_dz  = 1'b0;
		res_ovf = ctrl_f1.early_ovf;
		case (ctrl_f1.func)
			FN_DIV: begin
				if (ctrl_f1.dz) begin
					res_re  = '0;
					res_im  = '0;
					res_dz  = 1'b1;
					res_ovf = 1'b0;
				end else begin
					fre     = sat_f(ctrl_f1.neg_re, (DW+1)'(qm_re_f1), ctrl_f1.big_re);
					fim     = sat_f(ctrl_f1.neg_im, (DW+1)'(qm_im_f1), ctrl_f1.big_im);
					res_re  = fre[W-1:0];
					res_im  = fim[W-1:0];
					res_ovf = fre[W] | fim[W];
				end
			end
			FN_MAG_A, FN_MAG_B: begin
				fre     = sat_f(1'b0, (DW+1)'(root_f1), 1'b0);
				res_re  = fre[W-1:0];
				res_im  = '0;
				res_ovf = fre[W];
			end
			default: begin
				res_re = early_re_f1;
			end
		endcase
	end

	// Output register with a one-entry skid register behind it.
	logic         out_valid_q;
	logic [W-1:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
	logic         out_dz_q, out_ovf_q, skid_dz_q, skid_ovf_q;
	logic         take;

	assign take = out_valid_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= ctrl_f1.valid;
		end else if (ctrl_f1.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_re_q  <= skid_re_q;
				out_im_q  <= skid_im_q;
				out_dz_q  <= skid_dz_q;
				out_ovf_q <= skid_ovf_q;
			end
		end else if (!out_valid_q || take) begin
			out_re_q  <= res_re;
			out_im_q  <= res_im;
			out_dz_q  <= res_dz;
			out_ovf_q <= res_ovf;
		end else begin
			skid_re_q  <= res_re;
			skid_im_q  <= res_im;
			skid_dz_q  <= res_dz;
			skid_ovf_q <= res_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'({out_im_q, out_re_q});
	assign m_tuser  = {out_ovf_q, out_dz_q};

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
	import cau_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam logic [DW-1:0] Q_ONE = 1 << FB;
	localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam int RAND_ITEMS = 800;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	// One request as it goes into the unit.
	typedef struct {
		logic [2:0]    func;
		logic [DW-1:0] a_re, a_im, b_re, b_im;
	} request_t;

	// One result as it comes back.
	typedef struct packed {
		logic [DW-1:0] re, im;
		logic          dz, ovf;
	} result_t;

	// A row of the directed table; the typed result is used only when known is set.
	typedef struct {
		request_t req;
		logic     known;
		result_t  res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [4*DW-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*DW-1:0] m_tdata;
	logic [1:0] m_tuser;

	result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;

	always #1 clk = ~clk;

	complex_arith_unit_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Saturate an exact value to the fixed-point range, raising the flag on clipping.
	function automatic logic [DW-1:0] clamp(input logic signed [127:0] v, inout logic ovf);
		if (v > $signed({96'd0, Q_MAX})) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		if (v < -$signed({96'd0, Q_MAX}) - 1) begin
			ovf = 1'b1;
			return Q_MIN;
		end
		return v[DW-1:0];
	endfunction

	// Drop the fraction bits, rounding to nearest with ties away from zero.
	function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
		logic [127:0] m;
		m = v < 0 ? -v : v;
		m = (m + (128'd1 << (FB - 1))) >> FB;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	// Rounded quotient n * 2^FB / d, sign taken from the numerator.
	function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] n,
			input logic [127:0] d);
		logic [127:0] m, q;
		m = n < 0 ? -n : n;
		q = (m << (FB + 1)) / d;
		q = (q >> 1) + (q & 128'd1);
		return n < 0 ? -$signed(q) : $signed(q);
	endfunction

	// Square root of x^2 + y^2, rounded to nearest.
	function automatic logic signed [127:0] magnitude(input logic signed [127:0] x,
			input logic signed [127:0] y);
		logic [127:0] s, root, c;
		s = x * x + y * y;
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			c = root | (128'd1 << b);
			if (c * c <= s) root = c;
		end
		if (s - root * root > root) root = root + 1;
		return $signed(root);
	endfunction

	// Expected output of the unit for one request.
	function automatic result_t complex_result(input request_t r);
		logic signed [127:0] ar, ai, br, bi, re, im, den;
		result_t o;
		ar = $signed(r.a_re);
		ai = $signed(r.a_im);
		br = $signed(r.b_re);
		bi = $signed(r.b_im);
		re = '0;
		im = '0;
		o.dz = 1'b0;
		o.ovf = 1'b0;
		case (r.func)
			FN_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			FN_MUL: begin
				re = round_frac(ar * br - ai * bi);
				im = round_frac(ar * bi + ai * br);
			end
			FN_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					o.dz = 1'b1;
				end else begin
					re = scaled_quotient(ar * br + ai * bi, den);
					im = scaled_quotient(ai * br - ar * bi, den);
				end
			end
			FN_MAG_A: re = magnitude(ar, ai);
			FN_MAG_B: re = magnitude(br, bi);
			FN_CONJ_A: begin
				re = ar;
				im = -ai;
			end
			FN_CONJ_B: begin
				re = br;
				im = -bi;
			end
			default: ;
		endcase
		o.re = clamp(re, o.ovf);
		o.im = clamp(im, o.ovf);
		return o;
	endfunction

	// Operand values: full-range words, small and moderate numbers, and the extremes.
	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: return $urandom_range(0, 8 << FB) - (4 << FB);
			7: begin
				case ($urandom_range(0, 4))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return '0;
					3: return '1;
					default: return Q_ONE;
				endcase
			end
			default: return $urandom_range(0, 2000 << FB) - (1000 << FB);
		endcase
	endfunction

	// Idle length: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and wait until the unit takes it; the expectation is queued
	// at the accepting edge.
	task automatic send_request(input request_t r, input result_t res);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {r.b_im, r.b_re, r.a_im, r.a_re};
		s_tuser <= r.func;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(res);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stimulus: the directed table first, then random requests, then drain.
	initial begin
		row_t rows[$];
		row_t w;
		request_t r;
		result_t none;
		none = '{re: '0, im: '0, dz: 1'b0, ovf: 1'b0};
		// Simple sums, saturation both ways, unit product, zero divisor, magnitude, unused code.
		rows.push_back('{'{FN_ADD, Q_ONE, Q_ONE, Q_ONE, '0}, 1'b1,
			'{2 * Q_ONE, Q_ONE, 1'b0, 1'b0}});
		rows.push_back('{'{FN_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 1'b1,
			'{Q_MAX, Q_MIN, 1'b0, 1'b1}});
		rows.push_back('{'{FN_MUL, Q_ONE, '0, Q_ONE, '0}, 1'b1,
			'{Q_ONE, '0, 1'b0, 1'b0}});
		rows.push_back('{'{FN_DIV, Q_MAX, Q_MIN, '0, '0}, 1'b1,
			'{'0, '0, 1'b1, 1'b0}});
		rows.push_back('{'{FN_MAG_A, 3 * Q_ONE, 4 * Q_ONE, '0, '0}, 1'b1,
			'{5 * Q_ONE, '0, 1'b0, 1'b0}});
		// Conjugate of the most negative imaginary part clips to the largest value.
		rows.push_back('{'{FN_CONJ_A, Q_MIN, Q_MIN, '0, '0}, 1'b1,
			'{Q_MIN, Q_MAX, 1'b0, 1'b1}});
		rows.push_back('{'{FN_CONJ_B, '0, '0, Q_MAX, Q_MAX}, 1'b1,
			'{Q_MAX, Q_MIN + 1, 1'b0, 1'b0}});
		rows.push_back('{'{FN_UNUSED, Q_MAX, Q_MIN, Q_ONE, Q_ONE}, 1'b1, none});
		rows.push_back('{'{FN_ADD, '0, '0, '0, '0}, 1'b1, none});
		// Remaining rows are checked against the predictor.
		rows.push_back('{'{FN_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, none});
		rows.push_back('{'{FN_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, none});
		rows.push_back('{'{FN_MUL, 32'h0000_8000, '0, 32'h0000_0001, '0}, 1'b0, none});
		rows.push_back('{'{FN_MUL, 32'hFFFF_8000, '0, 32'h0000_0001, '0}, 1'b0, none});
		rows.push_back('{'{FN_DIV, Q_MAX, Q_MAX, 32'h0000_0001, '0}, 1'b0, none});
		rows.push_back('{'{FN_DIV, Q_ONE, '0, 3 * Q_ONE, '0}, 1'b0, none});
		rows.push_back('{'{FN_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, none});
		rows.push_back('{'{FN_DIV, Q_ONE, Q_ONE, '0, 32'hFFFF_FFFF}, 1'b0, none});
		rows.push_back('{'{FN_MAG_A, Q_MIN, Q_MIN, '0, '0}, 1'b0, none});
		rows.push_back('{'{FN_MAG_B, '0, '0, Q_MAX, 32'h0000_0001}, 1'b0, none});
		rows.push_back('{'{FN_MAG_B, '0, '0, Q_MIN, '0}, 1'b0, none});
		rows.push_back('{'{FN_CONJ_B, '0, '0, '1, Q_MIN}, 1'b0, none});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			w = rows[i];
			send_request(w.req, w.known ? w.res : complex_result(w.req));
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			r.func = ($urandom_range(0, 49) == 0) ? FN_UNUSED : 3'($urandom_range(0, 6));
			r.a_re = pick_operand();
			r.a_im = pick_operand();
			r.b_re = pick_operand();
			r.b_im = pick_operand();
			// Zero divisors now and then so the divide flag is hit at random too.
			if (r.func == FN_DIV && $urandom_range(0, 9) == 0) begin
				r.b_re = '0;
				r.b_im = '0;
			end
			send_request(r, complex_result(r));
		end
		s_tvalid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Result side: check each accepted result, then choose the next ready level.
	// Once, after a few hundred results, ready stays low long enough that the
	// pipeline fills and the request side stalls.
	initial begin
		result_t exp_res, got;
		int hold_left, gap_left;
		logic hold_done;
		hold_left = 0;
		gap_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.re = m_tdata[DW-1:0];
				got.im = m_tdata[2*DW-1:DW];
				got.dz = m_tuser[0];
				got.ovf = m_tuser[1];
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result re=%h im=%h dz=%b ovf=%b",
							got.re, got.im, got.dz, got.ovf);
				end else begin
					exp_res = pending_results.pop_front();
					if (got !== exp_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d: expected re=%h im=%h dz=%b ovf=%b, got re=%h im=%h dz=%b ovf=%b",
								results_seen, exp_res.re, exp_res.im, exp_res.dz, exp_res.ovf,
								got.re, got.im, got.dz, got.ovf);
					end
				end
			end
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else begin
				gap_left = pick_gap();
				m_tready <= (gap_left == 0);
			end
		end
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
